### rtl/csrp_pkg.sv
// csrp_pkg: shared types, constants and codes of the central spike rejection block
// used by every module under rtl; depends on nothing
package csrp_pkg;

	localparam int MAX_CANDLES_DEF = 15;
	localparam int CNT_W           = 6;
	localparam int PRICE_W         = 32;
	localparam int RATIO_W         = 20;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;
	localparam int JOB_DEPTH       = 2;

	localparam logic [RATIO_W-1:0] TOL_RST   = 20'd4588;
	localparam logic [RATIO_W-1:0] HEAD_RST  = 20'd68157;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 20'd65536;

	// register index, taken from paddr[2]
	localparam logic REG_TOL  = 1'b0;
	localparam logic REG_HEAD = 1'b1;

	typedef struct packed {
		logic signed [PRICE_W-1:0] open_price;
		logic signed [PRICE_W-1:0] high_price;
		logic signed [PRICE_W-1:0] low_price;
		logic signed [PRICE_W-1:0] close_price;
		logic                      last_candle;
	} candle_in_t;

	typedef struct packed {
		logic pattern_found;
		logic count_error;
	} verdict_t;

	typedef struct packed {
		logic signed [PRICE_W-1:0] open_p;
		logic signed [PRICE_W-1:0] high_p;
		logic signed [PRICE_W-1:0] low_p;
		logic signed [PRICE_W-1:0] close_p;
	} candle_t;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] n;
		logic             err;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [2:0] {
		EV_IDLE,
		EV_MID,
		EV_WALK,
		EV_DRAIN,
		EV_MUL,
		EV_CMP,
		EV_OUT
	} eval_state_t;

	typedef enum logic [1:0] {
		TAG_NONE,
		TAG_MID,
		TAG_SHLD
	} tag_t;

endpackage

### rtl/csrp_front.sv
// csrp_front: accepts candles, writes them into the free window bank, counts them
// and queues one job per window; depends on csrp_pkg
module csrp_front import csrp_pkg::*; #(
	parameter int MAX_CANDLES = MAX_CANDLES_DEF,
	localparam int IW = $clog2(MAX_CANDLES),
	localparam int AW = $clog2(2 * MAX_CANDLES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          candle_valid,
	output logic          candle_ready,
	input  candle_in_t    candle,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output candle_t       mem_wdata,
	output logic          job_push,
	output job_t          job,
	input  logic          job_full,
	input  release_t      rel
);

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             bank_q;
	logic [1:0]       busy_q;

	logic             accept;
	logic             room;
	logic [CNT_W-1:0] n_fill;
	logic             ovf_d;
	logic [1:0]       busy_set;
	logic [1:0]       busy_clr;

	assign candle_ready = !busy_q[bank_q] && !job_full;
	assign accept       = candle_valid && candle_ready;
	assign room         = cnt_q < CNT_W'(MAX_CANDLES);
	assign n_fill       = room ? cnt_q + 1'b1 : cnt_q;
	assign ovf_d        = ovf_q || !room;

	// bank 1 sits above bank 0 in the window memory
	assign mem_we    = accept && room;
	assign mem_waddr = bank_q ? AW'(cnt_q[IW-1:0]) + AW'(MAX_CANDLES) : AW'(cnt_q[IW-1:0]);
	assign mem_wdata = '{open_p:  candle.open_price,
	                     high_p:  candle.high_price,
	                     low_p:   candle.low_price,
	                     close_p: candle.close_price};

	assign job_push = accept && candle.last_candle;
	assign job.bank = bank_q;
	assign job.n    = n_fill;
	assign job.err  = ovf_d || (n_fill < CNT_W'(3)) || !n_fill[0];

	always_comb begin
		busy_set = '0;
		busy_clr = '0;
		if (job_push) begin
			busy_set[bank_q] = 1'b1;
		end
		if (rel.valid) begin
			busy_clr[rel.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= (busy_q | busy_set) & ~busy_clr;
			if (accept) begin
				if (candle.last_candle) begin
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
					bank_q <= ~bank_q;
				end else begin
					cnt_q <= n_fill;
					ovf_q <= ovf_d;
				end
			end
		end
	end

endmodule

### rtl/csrp_job_fifo.sv
// csrp_job_fifo: short job queue between the front and the evaluator
// depends on csrp_pkg
module csrp_job_fifo import csrp_pkg::*; #(
	localparam int PW = $clog2(JOB_DEPTH),
	localparam int FW = $clog2(JOB_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t dout,
	output logic full,
	output logic empty
);

	job_t          ent_q [JOB_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [FW-1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign full    = fill_q == FW'(JOB_DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(JOB_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(JOB_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### rtl/csrp_eval.sv
// csrp_eval: window memory, sequencer that walks one stored window per job,
// ratio checks and the verdict output register; depends on csrp_pkg
module csrp_eval import csrp_pkg::*; #(
	parameter int MAX_CANDLES = MAX_CANDLES_DEF,
	localparam int IW = $clog2(MAX_CANDLES),
	localparam int AW = $clog2(2 * MAX_CANDLES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mem_we,
	input  logic [AW-1:0]      mem_waddr,
	input  candle_t            mem_wdata,
	input  logic               job_empty,
	input  job_t               job_head,
	output logic               job_pop,
	input  logic [RATIO_W-1:0] tol,
	input  logic [RATIO_W-1:0] head,
	output logic               verdict_valid,
	input  logic               verdict_ready,
	output verdict_t           verdict,
	output release_t           rel
);

	candle_t mem [2 * MAX_CANDLES];
	candle_t rd_data_s1;

	eval_state_t state_q, state_d;
	job_t        job_q;
	logic [IW-1:0] idx_q;
	tag_t        tag_s1, tag_d;
	logic        last_s1, last_d;
	logic        rd_en;
	logic [IW-1:0] rd_idx;
	logic [AW-1:0] rd_addr;
	logic        out_load;

	candle_t                   mid_q;
	logic signed [PRICE_W-1:0] smax_q, smin_q, ceil_q;
	logic                      rng_ok_q, right_ok_q, found_q;
	logic [51:0]               prod_tol_q, prod_hr_q;
	logic signed [32:0]        spread_q, upper_q, range_q;
	logic [31:0]               body_q;
	logic                      out_valid_q;
	verdict_t                  out_q;

	logic [CNT_W-1:0]          half_n, n_m1;
	logic [IW-1:0]             mid_idx, last_idx;
	logic signed [PRICE_W-1:0] ceil_nx, oc_max, moc_max;
	logic [RATIO_W-1:0]        hr;
	logic [31:0]               smax_u;
	logic signed [32:0]        body_diff;
	logic signed [53:0]        al_l, al_r, dom_l, dom_r;
	logic signed [39:0]        w_up, w_body, w_rng, w_need;
	logic                      aligned, dominant, wick;

	assign half_n   = job_q.n >> 1;
	assign n_m1     = job_q.n - 1'b1;
	assign mid_idx  = half_n[IW-1:0];
	assign last_idx = n_m1[IW-1:0];
	assign rd_addr  = job_q.bank ? AW'(rd_idx) + AW'(MAX_CANDLES) : AW'(rd_idx);

	// window memory: one write port from the front, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			EV_IDLE: begin
				if (!job_empty) begin
					state_d = job_head.err ? EV_OUT : EV_MID;
				end
			end
			EV_MID: state_d = EV_WALK;
			EV_WALK: begin
				if (idx_q == last_idx) begin
					state_d = EV_DRAIN;
				end
			end
			EV_DRAIN: state_d = EV_MUL;
			EV_MUL:   state_d = EV_CMP;
			EV_CMP:   state_d = EV_OUT;
			EV_OUT: begin
				if (!out_valid_q || verdict_ready) begin
					state_d = EV_IDLE;
				end
			end
			default: state_d = EV_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		job_pop  = 1'b0;
		rd_en    = 1'b0;
		rd_idx   = idx_q;
		tag_d    = TAG_NONE;
		last_d   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			EV_IDLE: job_pop = !job_empty;
			EV_MID: begin
				rd_en  = 1'b1;
				rd_idx = mid_idx;
				tag_d  = TAG_MID;
			end
			EV_WALK: begin
				rd_en  = 1'b1;
				tag_d  = (idx_q == mid_idx) ? TAG_NONE : TAG_SHLD;
				last_d = idx_q == last_idx;
			end
			EV_OUT: out_load = !out_valid_q || verdict_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EV_IDLE;
			tag_s1      <= TAG_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			tag_s1      <= tag_d;
			out_valid_q <= (out_valid_q && !verdict_ready) || out_load;
		end
	end

	// shoulder accumulation
	assign oc_max  = (rd_data_s1.open_p > rd_data_s1.close_p) ? rd_data_s1.open_p
	                                                          : rd_data_s1.close_p;
	assign ceil_nx = (oc_max > ceil_q) ? oc_max : ceil_q;

	// ratio stage operands
	assign smax_u    = 32'(smax_q);
	assign hr        = (head < RATIO_ONE) ? RATIO_ONE : head;
	assign moc_max   = (mid_q.open_p > mid_q.close_p) ? mid_q.open_p : mid_q.close_p;
	assign body_diff = 33'(mid_q.close_p) - 33'(mid_q.open_p);

	// compare stage
	assign al_l     = {{5{spread_q[32]}}, spread_q, 16'd0};
	assign al_r     = {2'b00, prod_tol_q};
	assign dom_l    = {{6{mid_q.high_p[31]}}, mid_q.high_p, 16'd0};
	assign dom_r    = {2'b00, prod_hr_q};
	assign aligned  = al_l <= al_r;
	assign dominant = (dom_l >= dom_r) && (mid_q.high_p > smax_q);
	assign w_up     = 40'(upper_q) * 40'sd20;
	assign w_body   = $signed({8'd0, body_q}) * 40'sd30;
	assign w_rng    = 40'(range_q) * 40'sd6;
	assign w_need   = (w_body > w_rng) ? w_body : w_rng;
	assign wick     = w_up >= w_need;

	always_ff @(posedge clk) begin
		last_s1 <= last_d;
		if (state_q == EV_MID) begin
			idx_q <= '0;
		end else if (state_q == EV_WALK) begin
			idx_q <= idx_q + 1'b1;
		end

		if (job_pop) begin
			job_q      <= job_head;
			smax_q     <= '0;
			ceil_q     <= '0;
			rng_ok_q   <= 1'b1;
			right_ok_q <= 1'b0;
		end else begin
			case (tag_s1)
				TAG_MID: begin
					mid_q  <= rd_data_s1;
					smin_q <= rd_data_s1.high_p;
				end
				TAG_SHLD: begin
					if (!(rd_data_s1.high_p > rd_data_s1.low_p)) begin
						rng_ok_q <= 1'b0;
					end
					if (rd_data_s1.high_p > smax_q) begin
						smax_q <= rd_data_s1.high_p;
					end
					if (rd_data_s1.high_p < smin_q) begin
						smin_q <= rd_data_s1.high_p;
					end
					ceil_q <= ceil_nx;
					if (last_s1) begin
						right_ok_q <= (rd_data_s1.close_p < rd_data_s1.open_p) &&
						              (rd_data_s1.close_p <= ceil_nx);
					end
				end
				default: begin
				end
			endcase
		end

		if (state_q == EV_MUL) begin
			prod_tol_q <= 52'(smax_u) * 52'(tol);
			prod_hr_q  <= 52'(smax_u) * 52'(hr);
			spread_q   <= 33'(smax_q) - 33'(smin_q);
			upper_q    <= 33'(mid_q.high_p) - 33'(moc_max);
			range_q    <= 33'(mid_q.high_p) - 33'(mid_q.low_p);
			body_q     <= body_diff[32] ? 32'(-body_diff) : 32'(body_diff);
		end

		if (state_q == EV_CMP) begin
			found_q <= rng_ok_q && (mid_q.high_p > mid_q.low_p) && (smax_q > 0) &&
			           aligned && dominant && wick && right_ok_q;
		end

		if (out_load) begin
			out_q.pattern_found <= !job_q.err && found_q;
			out_q.count_error   <= job_q.err;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict       = out_q;
	assign rel.valid     = out_load;
	assign rel.bank      = job_q.bank;

endmodule

### rtl/central_spike_rejection_pattern.sv
// central_spike_rejection_pattern: top level with the register file and the
// front, job queue and evaluator; depends on csrp_pkg, csrp_front, csrp_job_fifo, csrp_eval

// A window of candles streams in on the candle channel, one transaction per candle,
// and the candle that carries last_candle closes the window; one verdict transaction
// follows per window. Every candle is taken as soon as it is offered while the window
// bank it lands in is free. Two banks of window memory sit behind the front, so the
// next window loads while the evaluator works on the previous one. The evaluator walks
// the closed window through the one read port of that memory: it reads the middle
// candle, then every candle, then runs the drain, multiply and compare steps and
// loads the output register; a window with a count error goes straight to the output
// register. Candles stall only when both banks hold windows not yet judged. The window
// stores are not cleared at reset; only entries written in the current window are read.
// Registers shoulder_tolerance (0x0) and the minimum peak ratio (0x4) are unsigned Q4.16;
// the user must write them only while the block is idle; the block does not enforce it.
module central_spike_rejection_pattern import csrp_pkg::*; #(
	parameter int MAX_CANDLES = MAX_CANDLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// candle channel
	input  logic               candle_valid,
	output logic               candle_ready,
	input  candle_in_t         candle,
	// verdict channel
	output logic               verdict_valid,
	input  logic               verdict_ready,
	output verdict_t           verdict,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(2 * MAX_CANDLES);

	// configuration registers
	logic [RATIO_W-1:0] tol_q;
	logic [RATIO_W-1:0] head_q;
	logic               reg_wr;

	// front to memory and queue
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	candle_t       mem_wdata;
	logic          job_push;
	job_t          job_in;
	job_t          job_head;
	logic          job_pop;
	logic          job_full;
	logic          job_empty;
	release_t      rel;

	// register write at the access phase, no wait states
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= TOL_RST;
			head_q <= HEAD_RST;
		end else if (reg_wr) begin
			case (paddr[2])
				REG_TOL:  tol_q  <= pwdata[RATIO_W-1:0];
				REG_HEAD: head_q <= pwdata[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read data follows the address, zero above the 20 ratio bits
	always_comb begin
		case (paddr[2])
			REG_TOL:  prdata = PDATA_W'(tol_q);
			REG_HEAD: prdata = PDATA_W'(head_q);
			default:  prdata = '0;
		endcase
	end

	// front: accept, store, count, close windows into jobs
	csrp_front #(
		.MAX_CANDLES (MAX_CANDLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.candle_valid (candle_valid),
		.candle_ready (candle_ready),
		.candle       (candle),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.job_push     (job_push),
		.job          (job_in),
		.job_full     (job_full),
		.rel          (rel)
	);

	// one queued job per closed window
	csrp_job_fifo u_jobs (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.dout   (job_head),
		.full   (job_full),
		.empty  (job_empty)
	);

	// back: walk the window and deliver the verdict
	csrp_eval #(
		.MAX_CANDLES (MAX_CANDLES)
	) u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.job_empty     (job_empty),
		.job_head      (job_head),
		.job_pop       (job_pop),
		.tol           (tol_q),
		.head          (head_q),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.verdict       (verdict),
		.rel           (rel)
	);

endmodule

### rtl/csrp_checker.sv
// csrp_checker: port level assertions for the central spike rejection block
// depends on csrp_pkg; bound to central_spike_rejection_pattern
module csrp_checker import csrp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               candle_valid,
	input logic               candle_ready,
	input candle_in_t         candle,
	input logic               verdict_valid,
	input logic               verdict_ready,
	input verdict_t           verdict,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata,
	input logic               pready
);

	// a waiting candle transaction holds until taken
	a_candle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		candle_valid && !candle_ready |=> candle_valid && $stable(candle))
		else $error("candle changed while waiting");

	// a stalled verdict transaction holds
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict))
		else $error("verdict changed while stalled");

	// a window with a count error never reports a pattern
	a_err_no_found: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> !(verdict.count_error && verdict.pattern_found))
		else $error("pattern reported on a count error");

	// register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// a written ratio reads back masked to its width
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready) ##1 (paddr[2] == $past(paddr[2]))
		|-> prdata == PDATA_W'($past(pwdata[RATIO_W-1:0])))
		else $error("register readback mismatch");

endmodule

bind central_spike_rejection_pattern csrp_checker u_csrp_checker (.*);
